@@ rtl/tkm_pkg.sv @@
// Shared constants, codes and controller/datapath link types for the trie keyword matcher.
package tkm_pkg;

  // Default table size
  localparam int TABLE_DEPTH_DEF = 1024;

  // Fixed field widths
  localparam int TABLE_ADDR_W = 10;
  localparam int BYTE_W       = 8;
  localparam int KEY_W        = 7;

  // Table entry encoding
  localparam logic [BYTE_W-1:0] FORK_BIT  = 8'h80;
  localparam logic [BYTE_W-1:0] LOW_SEVEN = 8'h7F;
  localparam logic [BYTE_W-1:0] TERM_CHAR = 8'h00;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_TOKEN = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic take_load;   // load transfer: write one table byte
    logic take_token;  // token transfer: latch the character
    logic rd_next;     // read the entry after the walk index
    logic idx_step;    // advance past a matched entry
    logic idx_skip;    // jump by the fork offset just read
    logic set_fail;    // mark the current word as failed
    logic res_capture; // capture the word result and restart the walk
    logic res_hit;     // captured result is a match (key from read data)
    logic out_load;    // move the captured result into the output register
  } tkm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic word_failed;
    logic char_zero;
    logic hit;
    logic is_fork;
    logic idx_ok;
    logic p1_ok;
    logic adv_ok;
    logic off_zero;
    logic out_busy;
  } tkm_sts_t;

endpackage

@@ rtl/tkm_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface tkm_req_if
  import tkm_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [TABLE_ADDR_W-1:0] table_addr;
  logic [BYTE_W-1:0]       table_byte;
  logic [BYTE_W-1:0]       token_char;

  modport source (output valid, req_type, table_addr, table_byte, token_char, input ready);
  modport sink   (input valid, req_type, table_addr, table_byte, token_char, output ready);
endinterface

interface tkm_res_if
  import tkm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             matched;
  logic [KEY_W-1:0] key_value;

  modport source (output valid, matched, key_value, input ready);
  modport sink   (input valid, matched, key_value, output ready);
endinterface

@@ rtl/tkm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tkm_dp.sv @@
// Datapath: trie table memory, walk index, failure flag and result registers.
module tkm_dp
  import tkm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tkm_cmd_t                cmd,
  output tkm_sts_t                sts,
  input  logic [TABLE_ADDR_W-1:0] in_addr,
  input  logic [BYTE_W-1:0]       in_byte,
  input  logic [BYTE_W-1:0]       in_char,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_matched,
  output logic [KEY_W-1:0]        out_key
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  // Walk index holds any entry index plus one fork offset
  localparam int PTR_W = $clog2(TABLE_DEPTH + 256);
  localparam int CMP_W = (PTR_W > TABLE_ADDR_W) ? PTR_W : TABLE_ADDR_W;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(TABLE_DEPTH);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

  logic [PTR_W-1:0]  idx;
  logic              failed;
  logic [BYTE_W-1:0] chr;
  logic              res_matched;
  logic [KEY_W-1:0]  res_key;

  logic [BYTE_W-1:0] rdata;
  logic [AW-1:0]     raddr;
  logic              we;
  logic              is_fork;
  logic              hit;
  logic [PTR_W-1:0]  idx_p1;
  logic [PTR_W-1:0]  idx_adv;
  logic [PTR_W-1:0]  idx_jmp;

  // Table memory
  assign we    = cmd.take_load && (CMP_W'(in_addr) < DEPTH_C);
  assign raddr = cmd.rd_next ? idx_p1[AW-1:0] : idx[AW-1:0];

  tkm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(in_addr)),
    .wdata (in_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entry compare and next-index candidates
  assign is_fork = (rdata & FORK_BIT) != TERM_CHAR;
  assign hit     = is_fork ? (chr == (rdata & LOW_SEVEN)) : (chr == rdata);
  assign idx_p1  = idx + PTR_W'(1);
  assign idx_adv = idx + (is_fork ? PTR_W'(2) : PTR_W'(1));
  assign idx_jmp = idx + PTR_W'(rdata);

  always_comb begin
    sts.word_failed = failed;
    sts.char_zero   = (chr == TERM_CHAR);
    sts.hit         = hit;
    sts.is_fork     = is_fork;
    sts.idx_ok      = idx < DEPTH_P;
    sts.p1_ok       = idx_p1 < DEPTH_P;
    sts.adv_ok      = idx_adv < DEPTH_P;
    sts.off_zero    = (rdata == TERM_CHAR);
    sts.out_busy    = out_valid;
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      failed <= 1'b0;
    end else if (cmd.res_capture) begin
      idx    <= '0;
      failed <= 1'b0;
    end else begin
      if (cmd.set_fail) failed <= 1'b1;
      if (cmd.idx_step) idx <= idx_adv;
      if (cmd.idx_skip) idx <= idx_jmp;
    end
  end

  // Character and word result
  always_ff @(posedge clk) begin
    if (cmd.take_token) chr <= in_char;
    if (cmd.res_capture) begin
      res_matched <= cmd.res_hit;
      res_key     <= cmd.res_hit ? KEY_W'(rdata & LOW_SEVEN) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_matched <= res_matched;
      out_key     <= res_key;
    end
  end

endmodule

@@ rtl/tkm_ctrl.sv @@
// Controller: sequences table reads for each character of the walk.
module tkm_ctrl
  import tkm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_type,
  output logic     in_ready,
  input  logic     out_ready,
  input  tkm_sts_t sts,
  output tkm_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ENT  = 7'b0000010,
    S_EVAL = 7'b0000100,
    S_SKIP = 7'b0001000,
    S_KEY  = 7'b0010000,
    S_KEYV = 7'b0100000,
    S_PUT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    fail       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_type == REQ_LOAD) begin
            cmd.take_load = 1'b1;
          end else begin
            cmd.take_token = 1'b1;
            state_next     = S_ENT;
          end
        end
      end
      // read the entry at the walk index
      S_ENT: begin
        if (sts.word_failed || !sts.idx_ok) begin
          fail = 1'b1;
        end else begin
          state_next = S_EVAL;
        end
      end
      // entry data valid; offset byte read in flight
      S_EVAL: begin
        cmd.rd_next = 1'b1;
        if (sts.hit) begin
          if (sts.char_zero) begin
            if (sts.adv_ok) begin
              cmd.idx_step = 1'b1;
              state_next   = S_KEY;
            end else begin
              fail = 1'b1;
            end
          end else begin
            cmd.idx_step = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (sts.is_fork && sts.p1_ok) begin
          state_next = S_SKIP;
        end else begin
          fail = 1'b1;
        end
      end
      // fork offset valid
      S_SKIP: begin
        if (sts.off_zero) begin
          fail = 1'b1;
        end else begin
          cmd.idx_skip = 1'b1;
          state_next   = S_ENT;
        end
      end
      S_KEY: begin
        state_next = S_KEYV;
      end
      S_KEYV: begin
        cmd.res_capture = 1'b1;
        cmd.res_hit     = 1'b1;
        state_next      = S_PUT;
      end
      S_PUT: begin
        if (!sts.out_busy || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Failed word: report at the terminator, otherwise remember it
    if (fail) begin
      if (sts.char_zero) begin
        cmd.res_capture = 1'b1;
        state_next      = S_PUT;
      end else begin
        cmd.set_fail = 1'b1;
        state_next   = S_IDLE;
      end
    end
  end

endmodule

@@ rtl/trie_table_keyword_matcher_core.sv @@
// Top level of the trie keyword matcher: controller, datapath and channel hookup.
//
// Usage: requests arrive on the req channel. A load request (req_type 0) writes
// table_byte at table_addr in the trie table; addresses at or past TABLE_DEPTH
// are dropped. A token request (req_type 1) brings one character of a word; a
// zero character ends the word and produces exactly one transfer on the res
// channel (matched, key_value), other characters produce none.
// A load is written while the block stays idle. A character is accepted and
// then reads and compares each entry it visits; a fork entry it skips also
// reads its offset byte. A character after a failure is accepted and dropped.
// The terminator also reads the key and loads the output register. The pace is
// set by the single read port of the table memory, which every step of the walk
// goes through.
// Reset clears the walk state and the output valid flag; table contents are not
// cleared and must be loaded before they are walked. A stalled receiver holds the
// result in the output register; the block keeps taking requests and only waits
// when a second result is ready before the first was taken.
module trie_table_keyword_matcher_core
  import tkm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  tkm_req_if.sink  req,
  tkm_res_if.source res
);

  tkm_cmd_t cmd;
  tkm_sts_t sts;

  tkm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_type   (req.req_type),
    .in_ready  (req.ready),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tkm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_addr     (req.table_addr),
    .in_byte     (req.table_byte),
    .in_char     (req.token_char),
    .out_ready   (res.ready),
    .out_valid   (res.valid),
    .out_matched (res.matched),
    .out_key     (res.key_value)
  );

endmodule

@@ test/tb.sv @@
// Testbench for the trie keyword matcher: directed cases, random trie images, word streams, scoreboard check.
`timescale 1ns / 1ps

module tb;
  import tkm_pkg::*;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int IMG_MAX      = 512;
  localparam int KW_MAX       = 64;
  localparam int MAX_LEVEL    = 3;

  typedef struct packed {
    logic                    req_type;
    logic [TABLE_ADDR_W-1:0] table_addr;
    logic [BYTE_W-1:0]       table_byte;
    logic [BYTE_W-1:0]       token_char;
  } match_req_t;

  typedef struct packed {
    logic             matched;
    logic [KEY_W-1:0] key_value;
  } word_verdict_t;

  typedef enum logic [1:0] {CHAR_CONSUMED, WORD_HIT, WORD_MISS} walk_outcome_e;

  // Scoreboard: shadow trie table plus walk state, and the verdicts still owed
  class match_scoreboard;
    bit [BYTE_W-1:0] trie_mem [TABLE_DEPTH_DEF];
    bit              written  [TABLE_DEPTH_DEF];
    int              cur_idx;
    bit              word_dead;
    word_verdict_t   word_verdicts [$];
    int              errors;

    // Walk one character from cur_idx; stops at the first unwritten entry it would read
    function walk_outcome_e follow_char(input logic [BYTE_W-1:0] ch, output int missing,
                                        output int next_at, output logic [KEY_W-1:0] key);
      int              at;
      logic [BYTE_W-1:0] entry;
      missing = -1;
      next_at = cur_idx;
      key     = '0;
      at      = cur_idx;
      while (at < TABLE_DEPTH_DEF) begin
        if (!written[at]) begin
          missing = at;
          return WORD_MISS;
        end
        entry = trie_mem[at];
        if ((entry & FORK_BIT) != 0) begin
          if (ch != (entry & LOW_SEVEN)) begin
            // fork miss: skip by the offset byte, zero offset or offset past end fails
            if (at + 1 >= TABLE_DEPTH_DEF) return WORD_MISS;
            if (!written[at + 1]) begin
              missing = at + 1;
              return WORD_MISS;
            end
            if (trie_mem[at + 1] == 0) return WORD_MISS;
            at = at + trie_mem[at + 1];
            continue;
          end
          at = at + 2;
        end else begin
          if (ch != entry) return WORD_MISS;
          at = at + 1;
        end
        if (ch == TERM_CHAR) begin
          if (at >= TABLE_DEPTH_DEF) return WORD_MISS;
          if (!written[at]) begin
            missing = at;
            return WORD_MISS;
          end
          key = trie_mem[at][KEY_W-1:0];
          return WORD_HIT;
        end
        next_at = at;
        return CHAR_CONSUMED;
      end
      return WORD_MISS;
    endfunction

    function int first_unwritten(input logic [BYTE_W-1:0] ch);
      int               missing;
      int               next_at;
      logic [KEY_W-1:0] key;
      if (word_dead) return -1;
      void'(follow_char(ch, missing, next_at, key));
      return missing;
    endfunction

    function void note_input(input match_req_t it);
      int               missing;
      int               next_at;
      logic [KEY_W-1:0] key;
      walk_outcome_e    outcome;
      word_verdict_t    v;
      if (it.req_type == REQ_LOAD) begin
        if (it.table_addr < TABLE_DEPTH_DEF) begin
          trie_mem[it.table_addr] = it.table_byte;
          written[it.table_addr]  = 1'b1;
        end
        return;
      end
      key     = '0;
      outcome = WORD_MISS;
      if (!word_dead) begin
        outcome = follow_char(it.token_char, missing, next_at, key);
        if (outcome == WORD_MISS) word_dead = 1'b1;
        else if (outcome == CHAR_CONSUMED) cur_idx = next_at;
      end
      // terminator closes the word and restarts the walk
      if (it.token_char == TERM_CHAR) begin
        v.matched   = (outcome == WORD_HIT);
        v.key_value = (outcome == WORD_HIT) ? key : '0;
        word_verdicts.push_back(v);
        cur_idx   = 0;
        word_dead = 1'b0;
      end
    endfunction

    function void check_result(input logic matched, input logic [KEY_W-1:0] key_value);
      word_verdict_t v;
      if (word_verdicts.size() == 0) begin
        $display("%0t: unexpected result matched=%0d key=%0h", $time, matched, key_value);
        errors++;
        return;
      end
      v = word_verdicts.pop_front();
      if (matched !== v.matched || key_value !== v.key_value) begin
        $display("%0t: result mismatch expected matched=%0d key=%0h actual matched=%0d key=%0h",
                 $time, v.matched, v.key_value, matched, key_value);
        errors++;
      end
    endfunction

    function int pending();
      return word_verdicts.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  tkm_req_if req_ch ();
  tkm_res_if res_ch ();

  trie_table_keyword_matcher_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  match_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_trigger  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int items_sent    = 0;

  // random trie image and the keywords it holds
  logic [BYTE_W-1:0] trie_img [IMG_MAX];
  int                img_len;
  logic [31:0]       kw_text  [KW_MAX];
  int                kw_len   [KW_MAX];
  int                kw_count;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_seen != hold_trigger) begin
      hold_seen    <= hold_trigger;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result transfers
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.matched, res_ch.key_value);
  end

  // One request transfer; valid stays high on return so back-to-back items need no toggle
  task automatic push_req(input match_req_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= it.req_type;
    req_ch.table_addr <= it.table_addr;
    req_ch.table_byte <= it.table_byte;
    req_ch.token_char <= it.token_char;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic load_byte(input int addr, input logic [BYTE_W-1:0] data);
    match_req_t it;
    it.req_type   = REQ_LOAD;
    it.table_addr = addr[TABLE_ADDR_W-1:0];
    it.table_byte = data;
    it.token_char = BYTE_W'($urandom_range(255));
    push_req(it);
  endtask

  // Token transfer; any table entry the walk would read unwritten gets loaded first
  task automatic send_char(input logic [BYTE_W-1:0] ch);
    match_req_t it;
    int         hole;
    hole = sb.first_unwritten(ch);
    while (hole >= 0) begin
      load_byte(hole, BYTE_W'($urandom_range(255)));
      hole = sb.first_unwritten(ch);
    end
    it.req_type   = REQ_TOKEN;
    it.table_addr = TABLE_ADDR_W'($urandom_range(1023));
    it.table_byte = BYTE_W'($urandom_range(255));
    it.token_char = ch;
    push_req(it);
  endtask

  task automatic send_word(input logic [63:0] text, input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) load_byte($urandom_range(1023), BYTE_W'($urandom_range(255)));
      send_char(text[8*i +: 8]);
    end
    send_char(TERM_CHAR);
  endtask

  function automatic void emit(input logic [BYTE_W-1:0] b);
    if (img_len < IMG_MAX) trie_img[img_len] = b;
    img_len++;
  endfunction

  // Lay out one trie node: each branch entry followed by its subtree, forks for all but maybe the last branch
  function automatic void grow_node(input int level, input logic [31:0] prefix);
    int                kids_n;
    logic [BYTE_W-1:0] kid [3];
    int                fork_at;
    int                gap;
    bit                dup;
    bit                as_fork;
    logic [31:0]       deeper;
    kids_n = (level >= MAX_LEVEL) ? 1 : (level == 0 ? $urandom_range(1, 3) : $urandom_range(1, 2));
    for (int j = 0; j < kids_n; j++) begin
      do begin
        kid[j] = (level >= MAX_LEVEL || $urandom_range(99) < 30) ? TERM_CHAR
                                                                 : BYTE_W'(8'h61 + $urandom_range(5));
        dup = 1'b0;
        for (int q = 0; q < j; q++) if (kid[q] == kid[j]) dup = 1'b1;
      end while (dup);
    end
    for (int j = 0; j < kids_n; j++) begin
      as_fork = (j < kids_n - 1) || ($urandom_range(3) == 0);
      fork_at = img_len;
      if (as_fork) begin
        emit(kid[j] | FORK_BIT);
        emit(8'h00);
      end else begin
        emit(kid[j]);
      end
      if (kid[j] == TERM_CHAR) begin
        emit(BYTE_W'($urandom_range(255)));
        if (kw_count < KW_MAX) begin
          kw_text[kw_count] = prefix;
          kw_len[kw_count]  = level;
          kw_count++;
        end
      end else begin
        deeper = prefix;
        deeper[8*level +: 8] = kid[j];
        grow_node(level + 1, deeper);
      end
      // patch the offset: next sibling, or for a trailing fork a dead end or short hop
      if (as_fork && fork_at + 1 < IMG_MAX) begin
        gap = (j < kids_n - 1) ? img_len - fork_at
                               : ($urandom_range(1) ? 0 : $urandom_range(1, 4));
        trie_img[fork_at + 1] = (gap > 255) ? 8'd255 : gap[7:0];
      end
    end
  endfunction

  task automatic random_word();
    logic [63:0] text;
    int          n;
    int          r;
    int          pos;
    r    = $urandom_range(kw_count - 1);
    text = {32'h0, kw_text[r]};
    n    = kw_len[r];
    r    = $urandom_range(99);
    if (r < 60) begin
      // known keyword as is
    end else if (r < 72) begin
      n = (n > 0) ? $urandom_range(n - 1) : 0;
    end else if (r < 86) begin
      if (n == 0) n = 1;
      pos = $urandom_range(n - 1);
      text[8*pos +: 8] = BYTE_W'($urandom_range(1, 255));
    end else if (r < 93) begin
      text[8*n +: 8] = BYTE_W'($urandom_range(1, 255));
      n++;
    end else begin
      n = $urandom_range(5);
      for (int i = 0; i < n; i++) text[8*i +: 8] = BYTE_W'($urandom_range(1, 255));
    end
    send_word(text, n);
  endtask

  initial begin
    int send_modes  [4];
    int stall_modes [4];
    int phase;
    int target;
    send_modes  = '{0, 80, 0, 9};
    stall_modes = '{0, 0, 80, 9};

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_LOAD;
    req_ch.table_addr <= '0;
    req_ch.table_byte <= '0;
    req_ch.token_char <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: fork chain from the root out to the table end
    load_byte(0, FORK_BIT | "c");
    load_byte(1, 8'd255);
    load_byte(2, "a");
    load_byte(3, TERM_CHAR);
    load_byte(255, FORK_BIT | "d");
    load_byte(256, 8'd255);
    load_byte(257, FORK_BIT | TERM_CHAR);
    load_byte(258, 8'h00);
    load_byte(259, 8'h2A);
    load_byte(510, FORK_BIT | "e");
    load_byte(511, 8'd255);
    load_byte(765, FORK_BIT | "f");
    load_byte(766, 8'd255);
    load_byte(1020, FORK_BIT | "g");
    load_byte(1021, 8'd2);
    load_byte(1022, FORK_BIT | TERM_CHAR);
    load_byte(1023, 8'd2);
    // "ca" matches through a plain terminator, key byte loaded mid-word
    send_char("c");
    load_byte(4, 8'hFF);
    send_char("a");
    send_char(TERM_CHAR);
    // "d" matches on a fork terminator
    send_char("d");
    send_char(TERM_CHAR);
    // zero fork offset fails the word, later characters ignored
    send_char("d");
    send_char("x");
    send_char("y");
    send_char(TERM_CHAR);
    // high character skips every fork and runs off the table
    send_char(8'hFF);
    send_char(TERM_CHAR);
    // empty word: terminator matches at the last entry, key would be past the end
    send_char(TERM_CHAR);

    // Random phases: fresh trie image, then a stream of words against it
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      send_idle_pct = send_modes[phase % 4];
      stall_pct     = stall_modes[phase % 4];
      img_len  = 0;
      kw_count = 0;
      grow_node(0, 32'h0);
      for (int a = 0; a < img_len && a < IMG_MAX; a++) load_byte(a, trie_img[a]);
      if (phase == 0) hold_trigger++;
      repeat ($urandom_range(15, 30)) random_word();
      phase++;
    end

    @(posedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tkm_pkg.sv
rtl/tkm_if.sv
rtl/tkm_ram.sv
rtl/tkm_dp.sv
rtl/tkm_ctrl.sv
rtl/trie_table_keyword_matcher_core.sv
test/tb.sv
